// ===== rtl/scg_pkg.sv =====
// Shared constants, types and helpers of the Scharr 3x3 gradient core.
package scg_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DIM_W  = 11;
	localparam int EXT_W  = 14;
	localparam int PIX_W  = 8;
	localparam int LINE_W = 2 * PIX_W;
	localparam int DIFF_W = 9;
	localparam int GRAD_W = 13;

	localparam int C_SIDE   = 3;
	localparam int C_CENTRE = 10;

	localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
	localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ACT_PIXEL = 1'b0,
		ACT_DRAIN = 1'b1
	} action_t;

	typedef struct packed {
		logic [EXT_W-1:0] width;
		logic [EXT_W-1:0] height;
	} dims_t;

	// vertical pass result handed from the front stage to the horizontal stage
	typedef struct packed {
		logic                     is_drain;
		logic                     has_res;
		logic                     col_first;
		logic                     col_second;
		logic                     last_col;
		logic                     drain_last;
		logic signed [GRAD_W-1:0] smooth;
		logic signed [DIFF_W-1:0] diff;
		logic signed [GRAD_W-1:0] drain_gx;
	} vert_t;

	// zero counts as one, anything above the maximum counts as the maximum
	function automatic logic [EXT_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		if (v == '0)
			eff_dim = EXT_W'(1);
		else if (ext > EXT_W'(maxv))
			eff_dim = EXT_W'(maxv);
		else
			eff_dim = ext;
	endfunction

endpackage

// ===== rtl/scg_line_mem.sv =====
// Two-row line store: one write port, two registered read ports.
module scg_line_mem (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [scg_pkg::COL_W-1:0]  wr_addr,
	input  logic [scg_pkg::LINE_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [scg_pkg::COL_W-1:0]  rd_addr_a,
	input  logic [scg_pkg::COL_W-1:0]  rd_addr_b,
	output logic [scg_pkg::LINE_W-1:0] rd_data_a,
	output logic [scg_pkg::LINE_W-1:0] rd_data_b
);

	// each entry: row above in the upper byte, row two above in the lower byte
	logic [scg_pkg::LINE_W-1:0] mem [scg_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ===== rtl/scg_front.sv =====
// Raster counters, line store access and the vertical pass.
module scg_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  scg_pkg::dims_t            dims,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic [scg_pkg::PIX_W-1:0] pixel,
	output logic                      vt_valid,
	input  logic                      vt_ready,
	output scg_pkg::vert_t            vt
);

	localparam int COL_W  = scg_pkg::COL_W;
	localparam int ROW_W  = scg_pkg::ROW_W;
	localparam int EXT_W  = scg_pkg::EXT_W;
	localparam int PIX_W  = scg_pkg::PIX_W;
	localparam int LINE_W = scg_pkg::LINE_W;
	localparam int GRAD_W = scg_pkg::GRAD_W;

	logic             in_fire, is_drain, s1_move, s1_wr;
	logic             last_col, last_row, drain_last;
	logic [COL_W-1:0] col_q, dk_q;
	logic [ROW_W-1:0] row_q;
	logic             dpend_q;
	logic [COL_W-1:0] addr_a, addr_b;

	logic             valid_s1;
	logic             drain_s1, row1_s1, row2_s1, c0_s1, c1_s1, last_s1;
	logic             dhas_s1, dlast_s1, dmid_s1, tall_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [COL_W-1:0] col_s1;
	logic             fwd_a_s1, fwd_b_s1;
	logic [LINE_W-1:0] fwd_s1;

	logic [LINE_W-1:0] rd_a, rd_b, ent_a, ent_b, wr_data;
	logic [PIX_W-1:0]  mid, above_v;
	logic [PIX_W:0]    pair_sum;
	logic [GRAD_W-1:0] smooth_u, drain_sa, drain_sb;

	function automatic logic [GRAD_W-1:0] line_smooth(input logic [LINE_W-1:0] e,
			input logic tall);
		logic [PIX_W-1:0] a;
		a = tall ? e[PIX_W-1:0] : e[LINE_W-1:PIX_W];
		line_smooth = GRAD_W'(a) * GRAD_W'(2 * scg_pkg::C_SIDE)
			+ GRAD_W'(e[LINE_W-1:PIX_W]) * GRAD_W'(scg_pkg::C_CENTRE);
	endfunction

	assign is_drain   = (action == scg_pkg::ACT_DRAIN);
	assign in_ready   = !valid_s1 || vt_ready;
	assign in_fire    = in_valid && in_ready;
	assign s1_move    = valid_s1 && vt_ready;
	assign s1_wr      = s1_move && !drain_s1;

	assign last_col   = (EXT_W'(col_q) + EXT_W'(1)) >= dims.width;
	assign last_row   = (EXT_W'(row_q) + EXT_W'(1)) >= dims.height;
	assign drain_last = (EXT_W'(dk_q) + EXT_W'(1)) >= dims.width;

	// drain tick k reads columns k+1 and k-1 of the last row
	assign addr_a = is_drain ? dk_q + COL_W'(1) : col_q;
	assign addr_b = dk_q - COL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			dpend_q <= 1'b0;
			dk_q    <= '0;
		end else if (in_fire) begin
			if (is_drain) begin
				if (dpend_q) begin
					if (drain_last)
						dpend_q <= 1'b0;
					else
						dk_q <= dk_q + COL_W'(1);
				end
			end else begin
				dpend_q <= 1'b0;
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						row_q   <= '0;
						dpend_q <= 1'b1;
						dk_q    <= '0;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			drain_s1 <= is_drain;
			pix_s1   <= pixel;
			col_s1   <= col_q;
			row1_s1  <= (row_q != '0);
			row2_s1  <= EXT_W'(row_q) >= EXT_W'(2);
			c0_s1    <= (col_q == '0);
			c1_s1    <= (col_q == COL_W'(1));
			last_s1  <= last_col;
			dhas_s1  <= dpend_q;
			dlast_s1 <= drain_last;
			dmid_s1  <= (dk_q != '0) && !drain_last;
			tall_s1  <= dims.height > EXT_W'(1);
			// the word leaving stage 1 writes the store at this very edge
			fwd_a_s1 <= s1_wr && (col_s1 == addr_a);
			fwd_b_s1 <= s1_wr && (col_s1 == addr_b);
			fwd_s1   <= wr_data;
		end
	end

	scg_line_mem u_mem (
		.clk       (clk),
		.wr_en     (s1_wr),
		.wr_addr   (col_s1),
		.wr_data   (wr_data),
		.rd_en     (in_fire),
		.rd_addr_a (addr_a),
		.rd_addr_b (addr_b),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	assign ent_a = fwd_a_s1 ? fwd_s1 : rd_a;
	assign ent_b = fwd_b_s1 ? fwd_s1 : rd_b;

	assign mid     = ent_a[LINE_W-1:PIX_W];
	assign above_v = row2_s1 ? ent_a[PIX_W-1:0] : pix_s1;
	assign wr_data = {pix_s1, mid};

	assign pair_sum = {1'b0, above_v} + {1'b0, pix_s1};
	assign smooth_u = GRAD_W'(pair_sum) * GRAD_W'(scg_pkg::C_SIDE)
		+ GRAD_W'(mid) * GRAD_W'(scg_pkg::C_CENTRE);

	assign drain_sa = line_smooth(ent_a, tall_s1);
	assign drain_sb = line_smooth(ent_b, tall_s1);

	assign vt_valid      = valid_s1;
	assign vt.is_drain   = drain_s1;
	assign vt.has_res    = drain_s1 ? dhas_s1 : row1_s1;
	assign vt.col_first  = c0_s1;
	assign vt.col_second = c1_s1;
	assign vt.last_col   = last_s1;
	assign vt.drain_last = dlast_s1;
	assign vt.smooth     = $signed(smooth_u);
	assign vt.diff       = $signed({1'b0, pix_s1}) - $signed({1'b0, above_v});
	assign vt.drain_gx   = dmid_s1 ? $signed(drain_sa - drain_sb) : '0;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !vt_ready |=> valid_s1 && $stable(col_s1) && $stable(pix_s1))
		else $error("stage 1 word changed while stalled");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !is_drain && last_col |=> col_q == '0)
		else $error("column count did not wrap at end of row");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !is_drain |=> !dpend_q || (col_q == '0 && row_q == '0 && dk_q == '0))
		else $error("drain pending without frame end");

endmodule

// ===== rtl/scg_back.sv =====
// Horizontal pass: vertical result windows, result sequencing and output register.
module scg_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              vt_valid,
	output logic                              vt_ready,
	input  scg_pkg::vert_t                    vt,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [scg_pkg::GRAD_W-1:0] grad_x,
	output logic signed [scg_pkg::GRAD_W-1:0] grad_y,
	output logic                              end_of_row,
	output logic                              end_of_frame
);

	localparam int GRAD_W = scg_pkg::GRAD_W;
	localparam int DIFF_W = scg_pkg::DIFF_W;

	localparam logic signed [GRAD_W-1:0] K_SIDE   = GRAD_W'(scg_pkg::C_SIDE);
	localparam logic signed [GRAD_W-1:0] K_SIDE2  = GRAD_W'(2 * scg_pkg::C_SIDE);
	localparam logic signed [GRAD_W-1:0] K_CENTRE = GRAD_W'(scg_pkg::C_CENTRE);

	logic take, emit, out_free, s2_done, sel_last;
	logic [1:0] nres;

	logic valid_s2, drain_s2, has_s2, c0_s2, c1_s2, last_s2, dlast_s2;
	logic signed [GRAD_W-1:0] dgx_s2;
	logic second_q;

	logic signed [GRAD_W-1:0] sw0_q, sw1_q, sw2_q;
	logic signed [DIFF_W-1:0] dw0_q, dw1_q, dw2_q;

	logic signed [GRAD_W-1:0] d_left, d_mid, d_right, d_last;
	logic signed [GRAD_W-1:0] gx_norm, gy_norm, gy_last;
	logic signed [GRAD_W-1:0] gx_nxt, gy_nxt;
	logic eor_nxt, eof_nxt;

	logic out_valid_q, eor_q, eof_q;
	logic signed [GRAD_W-1:0] gx_q, gy_q;

	function automatic logic signed [GRAD_W-1:0] sx(input logic signed [DIFF_W-1:0] v);
		sx = $signed({{(GRAD_W-DIFF_W){v[DIFF_W-1]}}, v});
	endfunction

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		if (!valid_s2 || !has_s2)
			nres = 2'd0;
		else if (drain_s2)
			nres = 2'd1;
		else
			nres = 2'(!c0_s2) + 2'(last_s2);
	end

	assign emit     = valid_s2 && (nres != 2'd0) && out_free;
	assign s2_done  = !valid_s2 || (nres == 2'd0) ||
		(out_free && ((nres == 2'd1) || second_q));
	assign vt_ready = s2_done;
	assign take     = vt_valid && vt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (vt_ready)
				valid_s2 <= vt_valid;
			if (emit)
				second_q <= (nres == 2'd2) && !second_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			drain_s2 <= vt.is_drain;
			has_s2   <= vt.has_res;
			c0_s2    <= vt.col_first;
			c1_s2    <= vt.col_second;
			last_s2  <= vt.last_col;
			dlast_s2 <= vt.drain_last;
			dgx_s2   <= vt.drain_gx;
			if (!vt.is_drain && vt.has_res) begin
				sw0_q <= sw1_q;
				sw1_q <= sw2_q;
				sw2_q <= vt.smooth;
				dw0_q <= dw1_q;
				dw1_q <= dw2_q;
				dw2_q <= vt.diff;
			end
		end
	end

	// on the second column the current column stands in for the missing left neighbour
	assign d_left  = c1_s2 ? sx(dw2_q) : sx(dw0_q);
	assign d_mid   = sx(dw1_q);
	assign d_right = sx(dw2_q);
	assign d_last  = c0_s2 ? sx(dw2_q) : sx(dw1_q);

	assign gx_norm = sw2_q - (c1_s2 ? sw2_q : sw0_q);
	assign gy_norm = K_SIDE * (d_left + d_right) + K_CENTRE * d_mid;
	assign gy_last = K_SIDE2 * d_last + K_CENTRE * d_right;

	assign sel_last = c0_s2 || second_q;

	always_comb begin
		if (drain_s2) begin
			gx_nxt  = dgx_s2;
			gy_nxt  = '0;
			eor_nxt = dlast_s2;
			eof_nxt = dlast_s2;
		end else if (sel_last) begin
			gx_nxt  = '0;
			gy_nxt  = gy_last;
			eor_nxt = 1'b1;
			eof_nxt = 1'b0;
		end else begin
			gx_nxt  = gx_norm;
			gy_nxt  = gy_norm;
			eor_nxt = 1'b0;
			eof_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			gx_q  <= gx_nxt;
			gy_q  <= gy_nxt;
			eor_q <= eor_nxt;
			eof_q <= eof_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign grad_x       = gx_q;
	assign grad_y       = gy_q;
	assign end_of_row   = eor_q;
	assign end_of_frame = eof_q;

	a_second_pair: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> valid_s2 && !drain_s2 && nres == 2'd2)
		else $error("second result pending on a word without two results");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !emit)
		else $error("held result overwritten");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("emitted result not presented");

endmodule

// ===== rtl/scg_core_top.sv =====
// Top level of the streaming Scharr 3x3 gradient core.
//
// Input channel (in_valid/in_ready): one word per pixel in raster order
// (action = pixel), or a drain tick (action = drain) after the frame's last
// pixel to read out the last row, one result per tick. Output channel
// (out_valid/out_ready): grad_x, grad_y and end_of_row/end_of_frame marks.
// Results lag one row and one pixel; the last pixel of a row from the
// second row on gives two results (row's penultimate and last column) when
// the row is wider than one pixel.
// A taken word passes stage 1 and stage 2, and its results leave through the
// output register, a second result following the first.
// Throughput: one word per cycle while out_ready stays high, set by the single
// output register; a two-result word holds the input while its second
// result leaves. Configuration (cfg_valid/cfg_ready, always ready)
// sets image_width (index 0) and image_height (index 1); write only when
// idle. Reset clears counters and handshakes, sets 640 x 480; the line
// store is not cleared. A stalled receiver fills the output register, then
// the two pipeline stages, then drops in_ready; nothing is lost.
module scharr_gradient_3x3_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [scg_pkg::DIM_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [scg_pkg::PIX_W-1:0]         pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [scg_pkg::GRAD_W-1:0] grad_x,
	output logic signed [scg_pkg::GRAD_W-1:0] grad_y,
	output logic                              end_of_row,
	output logic                              end_of_frame
);

	logic [scg_pkg::DIM_W-1:0] width_q, height_q;
	scg_pkg::dims_t            dims;
	scg_pkg::vert_t            vt;
	logic                      vt_valid, vt_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= scg_pkg::RESET_WIDTH;
			height_q <= scg_pkg::RESET_HEIGHT;
		end else if (cfg_valid) begin
			unique case (scg_pkg::cfg_reg_t'(cfg_index))
				scg_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				scg_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	assign dims.width  = scg_pkg::eff_dim(width_q, scg_pkg::MAX_WIDTH);
	assign dims.height = scg_pkg::eff_dim(height_q, scg_pkg::MAX_HEIGHT);

	scg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.dims     (dims),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.pixel    (pixel),
		.vt_valid (vt_valid),
		.vt_ready (vt_ready),
		.vt       (vt)
	);

	scg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.vt_valid     (vt_valid),
		.vt_ready     (vt_ready),
		.vt           (vt),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

endmodule

// ===== test/tb_scharr_gradient_3x3_core.sv =====
// Self-checking testbench for the streaming Scharr 3x3 gradient core.
module tb_scharr_gradient_3x3_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIX_W      = scg_pkg::PIX_W;
	localparam int GRAD_W     = scg_pkg::GRAD_W;
	localparam int DIM_W      = scg_pkg::DIM_W;
	localparam int MAX_WIDTH  = scg_pkg::MAX_WIDTH;
	localparam int MAX_HEIGHT = scg_pkg::MAX_HEIGHT;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 10;
	localparam int STREAM_WORDS = 650;

	typedef struct {
		scg_pkg::action_t act;
		logic [PIX_W-1:0] pix;
	} stream_word_t;

	typedef struct {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic                     eor;
		logic                     eof;
	} gradient_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = scg_pkg::REG_IMAGE_WIDTH;
	logic [DIM_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = scg_pkg::ACT_PIXEL;
	logic [PIX_W-1:0] pixel = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [GRAD_W-1:0] grad_x;
	logic signed [GRAD_W-1:0] grad_y;
	logic end_of_row;
	logic end_of_frame;

	scharr_gradient_3x3_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus and scoreboard
	stream_word_t stream_words[$];
	gradient_t    gradients_due[$];
	int           words_queued = 0;
	int           words_taken = 0;
	bit           word_taken = 1'b0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           mismatch_count = 0;
	int           cycle_count = 0;

	// predictor state
	logic [DIM_W-1:0] width_reg = scg_pkg::RESET_WIDTH;
	logic [DIM_W-1:0] height_reg = scg_pkg::RESET_HEIGHT;
	logic [PIX_W-1:0] row_above [MAX_WIDTH];
	logic [PIX_W-1:0] row_two_above [MAX_WIDTH];
	int               smooth_win [3] = '{0, 0, 0};
	int               diff_win [3] = '{0, 0, 0};
	int unsigned      col_pos = 0;
	int unsigned      row_pos = 0;
	int unsigned      drain_pos = 0;	// 0 = nothing to drain, else 1 + next column

	task automatic note_failure(input string msg);
		$display("[%0t] MISMATCH %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
		if (v == '0)
			return 1;
		return (v > lim) ? lim : int'(v);
	endfunction

	// vertical smoothing of the last row, rows mirrored about it
	function automatic int last_row_smooth(input int unsigned col, input int unsigned h);
		int mid;
		int outer;
		mid = row_above[col];
		outer = (h > 1) ? int'(row_two_above[col]) : mid;
		return 6 * outer + 10 * mid;
	endfunction

	task automatic push_gradient(input int gx, input int gy, input bit eor, input bit eof);
		gradient_t g;
		g.gx = gx[GRAD_W-1:0];
		g.gy = gy[GRAD_W-1:0];
		g.eor = eor;
		g.eof = eof;
		gradients_due.push_back(g);
	endtask

	task automatic predict_gradients(input scg_pkg::action_t act, input logic [PIX_W-1:0] pix);
		int unsigned w;
		int unsigned h;
		int unsigned k;
		int unsigned l;
		int unsigned r;
		int unsigned c;
		int p;
		int mid;
		int above;
		int li;
		bit lastcol;
		bit last;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		if (act == scg_pkg::ACT_DRAIN) begin
			if (drain_pos != 0) begin
				k = drain_pos - 1;
				l = (k > 0) ? k - 1 : ((k + 1 < w) ? k + 1 : 0);
				r = (k + 1 < w) ? k + 1 : ((k > 0) ? k - 1 : 0);
				last = (k + 1 >= w);
				// the mirrored rows cancel, so grad_y of the last row is zero
				push_gradient(last_row_smooth(r, h) - last_row_smooth(l, h), 0, last, last);
				drain_pos = last ? 0 : drain_pos + 1;
			end
		end else begin
			c = col_pos % MAX_WIDTH;
			p = pix;
			lastcol = (col_pos + 1 >= w);
			drain_pos = 0;
			if (row_pos >= 1) begin
				mid = row_above[c];
				above = (row_pos >= 2) ? int'(row_two_above[c]) : p;
				smooth_win[0] = smooth_win[1];
				smooth_win[1] = smooth_win[2];
				smooth_win[2] = 3 * (above + p) + 10 * mid;
				diff_win[0] = diff_win[1];
				diff_win[1] = diff_win[2];
				diff_win[2] = p - above;
				if (c >= 1) begin
					li = (c == 1) ? 2 : 0;
					push_gradient(smooth_win[2] - smooth_win[li],
						3 * (diff_win[li] + diff_win[2]) + 10 * diff_win[1], 1'b0, 1'b0);
				end
				if (lastcol) begin
					li = (c >= 1) ? 1 : 2;
					push_gradient(0, 6 * diff_win[li] + 10 * diff_win[2], 1'b1, 1'b0);
				end
			end
			row_two_above[c] = row_above[c];
			row_above[c] = pix;
			if (lastcol) begin
				col_pos = 0;
				if (row_pos + 1 >= h) begin
					row_pos = 0;
					drain_pos = 1;
				end else begin
					row_pos++;
				end
			end else begin
				col_pos++;
			end
		end
	endtask

	// checker, configuration tracking and prediction, all on the rising edge
	always @(posedge clk) begin
		gradient_t want;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("scharr_gradient_3x3_core verification failed");
				$finish;
			end else begin
				if (out_valid && out_ready) begin
					if (gradients_due.size() == 0) begin
						note_failure($sformatf("unexpected result gx=%0d gy=%0d",
							grad_x, grad_y));
					end else begin
						want = gradients_due.pop_front();
						if (grad_x !== want.gx)
							note_failure($sformatf("grad_x got %0d want %0d", grad_x, want.gx));
						if (grad_y !== want.gy)
							note_failure($sformatf("grad_y got %0d want %0d", grad_y, want.gy));
						if (end_of_row !== want.eor)
							note_failure($sformatf("end_of_row got %b want %b",
								end_of_row, want.eor));
						if (end_of_frame !== want.eof)
							note_failure($sformatf("end_of_frame got %b want %b",
								end_of_frame, want.eof));
					end
				end
				if (cfg_valid && cfg_ready) begin
					if (cfg_index == scg_pkg::REG_IMAGE_WIDTH)
						width_reg = cfg_data;
					else
						height_reg = cfg_data;
				end
				word_taken = in_valid && in_ready;
				if (word_taken) begin
					predict_gradients(scg_pkg::action_t'(action), pixel);
					words_taken++;
				end
			end
		end
	end

	// driver: input words and receiver back-pressure change on the falling edge
	always @(negedge clk) begin
		stream_word_t next_word;
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (!in_valid || word_taken) begin
				if (stream_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = stream_words.pop_front();
					in_valid <= 1'b1;
					action <= next_word.act;
					pixel <= next_word.pix;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic push_word(input scg_pkg::action_t act, input logic [PIX_W-1:0] pix);
		stream_word_t sw;
		sw.act = act;
		sw.pix = pix;
		stream_words.push_back(sw);
		words_queued++;
	endtask

	// style 1 keeps to full black and full white for the largest gradients
	task automatic queue_frame(input int w, input int h, input int drains, input int style);
		for (int i = 0; i < w * h; i++)
			push_word(scg_pkg::ACT_PIXEL, (style == 1) ? ($urandom_range(1) ? 8'hff : 8'h00)
				: PIX_W'($urandom_range(255)));
		for (int i = 0; i < drains; i++)
			push_word(scg_pkg::ACT_DRAIN, PIX_W'($urandom_range(255)));
	endtask

	task automatic wait_quiet();
		do @(negedge clk);
		while (words_taken != words_queued || gradients_due.size() != 0);
		// words that give no result may still be in the pipeline
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input scg_pkg::cfg_reg_t idx, input logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic start_phase(input logic [DIM_W-1:0] wreg, input logic [DIM_W-1:0] hreg,
		input int mode);
		wait_quiet();
		write_reg(scg_pkg::REG_IMAGE_WIDTH, wreg);
		write_reg(scg_pkg::REG_IMAGE_HEIGHT, hreg);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
			default: begin send_idle_pct = 36; recv_stall_pct = 36; end
		endcase
	endtask

	initial begin
		logic [PIX_W-1:0] opening_frame [9];
		int phase_no;
		int w;
		int h;
		int frames;
		int drains;
		opening_frame = '{8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 3x3 frame at the pixel extremes, full drain and one drain with nothing pending
		start_phase(DIM_W'(3), DIM_W'(3), 0);
		for (int i = 0; i < 9; i++)
			push_word(scg_pkg::ACT_PIXEL, opening_frame[i]);
		for (int i = 0; i < 4; i++)
			push_word(scg_pkg::ACT_DRAIN, PIX_W'($urandom_range(255)));

		// width register zero counts as one; second pixel drops the pending drain
		start_phase(DIM_W'(0), DIM_W'(1), 3);
		push_word(scg_pkg::ACT_PIXEL, 8'h5a);
		push_word(scg_pkg::ACT_PIXEL, 8'ha5);
		push_word(scg_pkg::ACT_DRAIN, 8'h00);

		// single column frame
		start_phase(DIM_W'(1), DIM_W'(3), 2);
		queue_frame(1, 3, 1, 0);

		phase_no = 0;
		while (words_queued < STREAM_WORDS) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			h = $urandom_range(1, 6);
			start_phase((w == 1 && $urandom_range(1)) ? DIM_W'(0) : DIM_W'(w),
				(h == 1 && $urandom_range(1)) ? DIM_W'(0) : DIM_W'(h), phase_no);
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				if (words_queued >= STREAM_WORDS)
					break;
				// mostly a full drain, sometimes cut short by the next frame
				if ($urandom_range(3) != 0)
					drains = w + $urandom_range(0, 2);
				else
					drains = $urandom_range(0, w - 1);
				queue_frame(w, h, drains, ($urandom_range(3) == 0) ? 1 : 0);
			end
			phase_no++;
		end

		wait_quiet();
		if (mismatch_count == 0)
			$display("scharr_gradient_3x3_core verification clean");
		else
			$display("scharr_gradient_3x3_core verification failed");
		$finish;
	end

endmodule

// ===== scharr_gradient_3x3_core.f =====
rtl/scg_pkg.sv
rtl/scg_line_mem.sv
rtl/scg_front.sv
rtl/scg_back.sv
rtl/scg_core_top.sv
test/tb_scharr_gradient_3x3_core.sv
